/* design/grey_pixel_recolor_checker_assert.svh */
// Assertion macros for the grey pixel recolor checker.
// Expects clk and rst_n in the scope of each use; empty bodies when SYNTH is set.
`ifndef GREY_PIXEL_RECOLOR_CHECKER_ASSERT_SVH
`define GREY_PIXEL_RECOLOR_CHECKER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define GPRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gprc assertion failed");

// Next-cycle implication
`define GPRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gprc assertion failed");

`else

`define GPRC_ASSERT_NOW(lbl, ante, cons)
`define GPRC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/gprc_pkg.sv */
// Shared constants and types for the grey pixel recolor checker.
// No dependencies; used by the channel interfaces and the top level.
package gprc_pkg;

  // Field widths
  localparam int X_W   = 12;
  localparam int Y_W   = 12;
  localparam int PIX_W = 32;
  localparam int CFG_W = 13;

  // Largest coordinate value a field can carry
  localparam int COORD_MAX = 4095;

  // Parameter defaults
  localparam int CHECKER_CELLS_DEF = 40;
  localparam int MAX_DIM_DEF       = 4096;
  localparam int DIM_RESET         = 256;

  // Classification thresholds
  localparam int GREY_LIMIT   = 64 * 64;
  localparam int BRIGHT_ABOVE = 192;
  localparam int DARK_BELOW   = 5;

  // Divide by three: floor(n / 3) == (n * 683) >> 11 for n < 2048
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  // Quotient bits resolved per divider stage
  localparam int DIV_BPS = 3;

  // Replacement colors, packed blue[23:16] green[15:8] red[7:0]
  localparam logic [23:0] SKIN_RGB = 24'hAFC8FF;
  localparam logic [23:0] RED_RGB  = 24'h1414FF;
  localparam logic [23:0] CYAN_RGB = 24'hFFFF14;

  // Configuration register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Pixel class carried down the pipeline
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_PASS   = 2'd0;
  localparam cls_t CLS_BRIGHT = 2'd1;
  localparam cls_t CLS_DARK   = 2'd2;

endpackage

/* design/gprc_if.sv */
// Valid/ready channel interfaces for the grey pixel recolor checker.
// Depends on gprc_pkg for field widths.

// Input channel: one pixel with its coordinates
interface gprc_in_if;
  logic                         valid;
  logic                         ready;
  logic [gprc_pkg::X_W-1:0]     pixel_x;
  logic [gprc_pkg::Y_W-1:0]     pixel_y;
  logic [gprc_pkg::PIX_W-1:0]   pixel_in;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_in,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_in,
                  output ready);
endinterface

// Result channel: one recolored pixel
interface gprc_out_if;
  logic                         valid;
  logic                         ready;
  logic [gprc_pkg::PIX_W-1:0]   pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

/* design/grey_pixel_recolor_checker.sv */
// Top level of the grey pixel recolor checker: classification pipeline,
// pipelined restoring dividers for the checker cell, output skid buffer.
// Depends on gprc_pkg, gprc_if.sv and grey_pixel_recolor_checker_assert.svh.
//
// Usage:
//  - in_ch carries pixel_x, pixel_y and pixel_in (R 7:0, G 15:8, B 23:16, A 31:24);
//    a transaction completes when valid and ready are both high.
//  - out_ch carries pixel_out in the same layout, alpha copied from the input.
//  - APB port: image_width at 0x0, image_height at 0x4, 13-bit values; 0 is held
//    as 1, values above MAX_DIM as MAX_DIM. Write only while no pixel is in flight.
//  - Pipeline: channel sum, grey level, squared deviations, class, then the divider
//    stages over NUM_W = bits of 4095 * CHECKER_CELLS, then the output register.
//  - Throughput: one pixel per cycle with no stall. The checker cell parity comes
//    from two restoring dividers (x and y) resolving three quotient bits per stage.
//  - Reset (rst_n low, synchronous) empties the pipeline and sets both dimensions
//    to 256, or to MAX_DIM if smaller; configuration is not lost otherwise.
//  - When out_ch.ready is low the result holds, one more result parks in a skid
//    register, and then the whole pipeline freezes with in_ch.ready low.
//    Nothing is dropped or repeated.
`include "grey_pixel_recolor_checker_assert.svh"

module grey_pixel_recolor_checker #(
  parameter int CHECKER_CELLS = gprc_pkg::CHECKER_CELLS_DEF,
  parameter int MAX_DIM       = gprc_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gprc_in_if.sink                         in_ch,
  gprc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gprc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gprc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gprc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  // Derived sizes
  localparam int DIM_W = (MAX_DIM >= 8191) ? gprc_pkg::CFG_W : $clog2(MAX_DIM + 1);
  localparam int RW    = DIM_W + 1;
  localparam int NUM_W = $clog2(gprc_pkg::COORD_MAX * CHECKER_CELLS + 1);
  localparam int DIV_STAGES = (NUM_W + gprc_pkg::DIV_BPS - 1) / gprc_pkg::DIV_BPS;
  localparam int P     = DIV_STAGES * gprc_pkg::DIV_BPS;
  localparam int DIM_RESET_V = (MAX_DIM < gprc_pkg::DIM_RESET) ? MAX_DIM
                                                               : gprc_pkg::DIM_RESET;
  localparam int PW = gprc_pkg::PIX_W;

  typedef struct packed {
    logic [PW-1:0]     pix;
    gprc_pkg::cls_t    cls;
    logic [RW-1:0]     rx;
    logic [RW-1:0]     ry;
    logic [P-1:0]      nx;
    logic [P-1:0]      ny;
    logic              qx;
    logic              qy;
  } dstage_t;

  // Zero reads as one, oversize reads as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [gprc_pkg::CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic bit_in,
                                           input logic [DIM_W-1:0] dv);
    logic [RW-1:0] sh;
    logic [RW:0]   res;
    sh = {rem[RW-2:0], bit_in};
    if (sh >= {1'b0, dv}) begin
      res = {1'b1, sh - {1'b0, dv}};
    end else begin
      res = {1'b0, sh};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------
  // Configuration registers
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(DIM_RESET_V);
      height_r <= DIM_W'(DIM_RESET_V);
    end else if (cfg_wr) begin
      if (paddr[gprc_pkg::APB_ADDR_W-1] == gprc_pkg::REG_HEIGHT) begin
        height_r <= clamp_dim(pwdata[gprc_pkg::CFG_W-1:0]);
      end else begin
        width_r  <= clamp_dim(pwdata[gprc_pkg::CFG_W-1:0]);
      end
    end
  end

  always_comb begin
    if (paddr[gprc_pkg::APB_ADDR_W-1] == gprc_pkg::REG_WIDTH) begin
      prdata = gprc_pkg::APB_DATA_W'(width_r);
    end else begin
      prdata = gprc_pkg::APB_DATA_W'(height_r);
    end
  end

  // ---------------------------------------------------------------
  // Pipeline enable: frozen only while the skid register is occupied
  logic en;
  logic skid_valid_r;
  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  // Stage 1: channel sum and cell numerators
  logic          s1_valid_r;
  logic [PW-1:0] s1_pix_r;
  logic [9:0]    s1_sum_r;
  logic [P-1:0]  s1_nx_r;
  logic [P-1:0]  s1_ny_r;

  // Stage 2: grey level
  logic          s2_valid_r;
  logic [PW-1:0] s2_pix_r;
  logic [7:0]    s2_grey_r;
  logic [P-1:0]  s2_nx_r;
  logic [P-1:0]  s2_ny_r;
  logic [19:0]   grey_prod;

  // Stage 3: squared deviations, bright and dark flags
  logic                s3_valid_r;
  logic [PW-1:0]       s3_pix_r;
  logic [15:0]         s3_sqr_r;
  logic [15:0]         s3_sqg_r;
  logic [15:0]         s3_sqb_r;
  logic                s3_bright_r;
  logic                s3_dark_r;
  logic [P-1:0]        s3_nx_r;
  logic [P-1:0]        s3_ny_r;
  logic signed [17:0]  dev_r;
  logic signed [17:0]  dev_g;
  logic signed [17:0]  dev_b;
  logic signed [17:0]  sqr_nxt;
  logic signed [17:0]  sqg_nxt;
  logic signed [17:0]  sqb_nxt;

  // Stage 4: class, entry of the divider
  logic           s4_valid_r;
  dstage_t        s4_r;
  logic [17:0]    sq_sum;
  gprc_pkg::cls_t cls_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  assign grey_prod = 20'(s1_sum_r) * 20'(gprc_pkg::DIV3_MUL);

  // Deviations from grey, squared in an 18-bit signed context
  always_comb begin
    dev_r   = 18'(s2_pix_r[7:0])   - 18'(s2_grey_r);
    dev_g   = 18'(s2_pix_r[15:8])  - 18'(s2_grey_r);
    dev_b   = 18'(s2_pix_r[23:16]) - 18'(s2_grey_r);
    sqr_nxt = dev_r * dev_r;
    sqg_nxt = dev_g * dev_g;
    sqb_nxt = dev_b * dev_b;
  end

  // Near-grey test and class
  always_comb begin
    sq_sum  = 18'(s3_sqr_r) + 18'(s3_sqg_r) + 18'(s3_sqb_r);
    cls_nxt = gprc_pkg::CLS_PASS;
    if (sq_sum < 18'(gprc_pkg::GREY_LIMIT)) begin
      if (s3_bright_r) begin
        cls_nxt = gprc_pkg::CLS_BRIGHT;
      end else if (s3_dark_r) begin
        cls_nxt = gprc_pkg::CLS_DARK;
      end
    end
  end

  // Front stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix_r <= in_ch.pixel_in;
      s1_sum_r <= 10'(in_ch.pixel_in[7:0]) + 10'(in_ch.pixel_in[15:8])
                + 10'(in_ch.pixel_in[23:16]);
      s1_nx_r  <= P'(32'(in_ch.pixel_x) * 32'(CHECKER_CELLS));
      s1_ny_r  <= P'(32'(in_ch.pixel_y) * 32'(CHECKER_CELLS));

      s2_pix_r  <= s1_pix_r;
      s2_grey_r <= grey_prod[gprc_pkg::DIV3_SHIFT+7:gprc_pkg::DIV3_SHIFT];
      s2_nx_r   <= s1_nx_r;
      s2_ny_r   <= s1_ny_r;

      s3_pix_r    <= s2_pix_r;
      s3_sqr_r    <= sqr_nxt[15:0];
      s3_sqg_r    <= sqg_nxt[15:0];
      s3_sqb_r    <= sqb_nxt[15:0];
      s3_bright_r <= s2_grey_r > 8'(gprc_pkg::BRIGHT_ABOVE);
      s3_dark_r   <= s2_grey_r < 8'(gprc_pkg::DARK_BELOW);
      s3_nx_r     <= s2_nx_r;
      s3_ny_r     <= s2_ny_r;

      s4_r.pix <= s3_pix_r;
      s4_r.cls <= cls_nxt;
      s4_r.rx  <= '0;
      s4_r.ry  <= '0;
      s4_r.nx  <= s3_nx_r;
      s4_r.ny  <= s3_ny_r;
      s4_r.qx  <= 1'b0;
      s4_r.qy  <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Divider stages: x*CELLS/width and y*CELLS/height, MSB first
  logic [DIV_STAGES-1:0] dv_r;
  dstage_t               d_r   [DIV_STAGES];
  dstage_t               d_src [DIV_STAGES];
  dstage_t               d_nxt [DIV_STAGES];

  always_comb begin
    d_src[0] = s4_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      d_src[k] = d_r[k-1];
    end
  end

  always_comb begin
    logic [RW:0] stx;
    logic [RW:0] sty;
    for (int k = 0; k < DIV_STAGES; k++) begin
      d_nxt[k] = d_src[k];
      for (int j = 0; j < gprc_pkg::DIV_BPS; j++) begin
        stx = div_step(d_nxt[k].rx, d_nxt[k].nx[P-1], width_r);
        sty = div_step(d_nxt[k].ry, d_nxt[k].ny[P-1], height_r);
        d_nxt[k].qx = stx[RW];
        d_nxt[k].rx = stx[RW-1:0];
        d_nxt[k].qy = sty[RW];
        d_nxt[k].ry = sty[RW-1:0];
        d_nxt[k].nx = {d_nxt[k].nx[P-2:0], 1'b0};
        d_nxt[k].ny = {d_nxt[k].ny[P-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r[0] <= s4_valid_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        d_r[k] <= d_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------
  // Final color select; the last quotient bits give the cell parity
  dstage_t       last;
  logic          last_valid;
  logic [PW-1:0] result_nxt;

  assign last       = d_r[DIV_STAGES-1];
  assign last_valid = dv_r[DIV_STAGES-1];

  always_comb begin
    case (last.cls)
      gprc_pkg::CLS_BRIGHT: result_nxt = {last.pix[31:24], gprc_pkg::SKIN_RGB};
      gprc_pkg::CLS_DARK: begin
        if (last.qx ^ last.qy) begin
          result_nxt = {last.pix[31:24], gprc_pkg::CYAN_RGB};
        end else begin
          result_nxt = {last.pix[31:24], gprc_pkg::RED_RGB};
        end
      end
      default: result_nxt = last.pix;
    endcase
  end

  // ---------------------------------------------------------------
  // Output register plus skid register
  logic          out_valid_r;
  logic [PW-1:0] out_data_r;
  logic [PW-1:0] skid_data_r;
  logic          push;
  logic          out_fire;

  assign push     = last_valid && en;
  assign out_fire = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= result_nxt;
      end
    end else if (push) begin
      skid_data_r <= result_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_data_r;

  // ---------------------------------------------------------------
  // Assertions

  // The skid register only holds a transaction behind a full output register
  `GPRC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)

  // The skid register fills only when the output was stalled
  `GPRC_ASSERT_NOW(a_skid_fill_on_stall, $rose(skid_valid_r), $past(out_valid_r && !out_ch.ready))

  // A frozen pipeline keeps its last-stage transaction
  `GPRC_ASSERT_NEXT(a_last_held_on_freeze, !en && last_valid, last_valid)

endmodule
